// ----- sv/lzbr_pkg.sv -----
`default_nettype none

package lzbr_pkg;

    localparam int WINDOW_DEPTH = 32768;
    localparam int MAX_MATCH    = 258;
    localparam int LANE_BYTES   = 8;
    localparam int QUEUE_DEPTH  = 4;

    localparam int ADDR_W     = $clog2(WINDOW_DEPTH);
    localparam int HELD_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int DIST_W     = 16;
    localparam int LEN_W      = 9;
    localparam int DATA_W     = 64;
    localparam int COUNT_W    = 4;
    localparam int LANE_IDX_W = (LANE_BYTES > 1) ? $clog2(LANE_BYTES) : 1;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    localparam logic MODE_LITERAL = 1'b0;
    localparam logic MODE_MATCH   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FAR   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_LITERAL,
        CMD_COPY,
        CMD_EMPTY,
        CMD_FAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        lit;
        logic [DIST_W-1:0] distance;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_COPY
    } back_state_t;

endpackage

`default_nettype wire

// ----- sv/lzbr_ram.sv -----
`default_nettype none

module lzbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/lzbr_front.sv -----
`default_nettype none

module lzbr_front (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          mode,
    input  wire [7:0]                    literal_byte,
    input  wire [lzbr_pkg::DIST_W-1:0]   distance,
    input  wire [lzbr_pkg::LEN_W-1:0]    length,
    input  wire                          q_ready,
    output logic                         q_push,
    output lzbr_pkg::cmd_t               q_cmd
);

    logic [lzbr_pkg::HELD_W-1:0] held_reg;
    logic [lzbr_pkg::HELD_W-1:0] held_next;
    logic [lzbr_pkg::LEN_W-1:0]  len_clamped;
    logic [lzbr_pkg::HELD_W:0]   held_sum;
    logic [lzbr_pkg::HELD_W:0]   add_amount;

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

    always_comb begin
        len_clamped = (length > lzbr_pkg::LEN_W'(lzbr_pkg::MAX_MATCH))
                    ? lzbr_pkg::LEN_W'(lzbr_pkg::MAX_MATCH) : length;

        q_cmd.lit      = literal_byte;
        q_cmd.distance = distance;
        q_cmd.len      = len_clamped;
        add_amount     = '0;

        if (mode == lzbr_pkg::MODE_LITERAL) begin
            q_cmd.kind = lzbr_pkg::CMD_LITERAL;
            add_amount = (lzbr_pkg::HELD_W+1)'(1);
        end else if (distance == '0 || length == '0) begin
            q_cmd.kind = lzbr_pkg::CMD_EMPTY;
        end else if (distance > lzbr_pkg::DIST_W'(held_reg)) begin
            q_cmd.kind = lzbr_pkg::CMD_FAR;
        end else begin
            q_cmd.kind = lzbr_pkg::CMD_COPY;
            add_amount = (lzbr_pkg::HELD_W+1)'(len_clamped);
        end

        held_sum  = {1'b0, held_reg} + add_amount;
        held_next = (held_sum > (lzbr_pkg::HELD_W+1)'(lzbr_pkg::WINDOW_DEPTH))
                  ? lzbr_pkg::HELD_W'(lzbr_pkg::WINDOW_DEPTH)
                  : held_sum[lzbr_pkg::HELD_W-1:0];
    end

    // history fill level, tracked at acceptance so the back end can lag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (q_push) begin
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lzbr_queue.sv -----
`default_nettype none

module lzbr_queue (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  lzbr_pkg::cmd_t  push_cmd,
    output logic            push_ready,
    input  wire             pop,
    output logic            head_valid,
    output lzbr_pkg::cmd_t  head_cmd
);

    lzbr_pkg::cmd_t              entry_reg [lzbr_pkg::QUEUE_DEPTH];
    logic [lzbr_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [lzbr_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [lzbr_pkg::QPTR_W:0]   fill_reg;
    logic [lzbr_pkg::QPTR_W:0]   fill_next;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (fill_reg != (lzbr_pkg::QPTR_W+1)'(lzbr_pkg::QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lzbr_back.sv -----
`default_nettype none

module lzbr_back (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cmd_valid,
    input  lzbr_pkg::cmd_t                   cmd,
    output logic                             cmd_pop,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [lzbr_pkg::DATA_W-1:0]      out_data,
    output logic [lzbr_pkg::COUNT_W-1:0]     out_count,
    output logic                             out_last,
    output lzbr_pkg::status_t                out_status
);

    localparam int LB = lzbr_pkg::LANE_BYTES;
    localparam int AW = lzbr_pkg::ADDR_W;

    lzbr_pkg::back_state_t state_reg, state_next;

    logic [AW-1:0]                   wp_reg, wp_next;
    logic [lzbr_pkg::DIST_W-1:0]     dist_reg, dist_next;
    logic [lzbr_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [lzbr_pkg::LEN_W-1:0]      cnt_reg, cnt_next;
    logic [lzbr_pkg::LANE_IDX_W-1:0] acc_cnt_reg, acc_cnt_next;
    logic [LB-1:0][7:0]              acc_reg, acc_next;
    logic [7:0]                      last_byte_reg, last_byte_next;

    logic                            ov_reg, ov_next;
    logic [lzbr_pkg::DATA_W-1:0]     od_reg, od_next;
    logic [lzbr_pkg::COUNT_W-1:0]    oc_reg, oc_next;
    logic                            ol_reg, ol_next;
    lzbr_pkg::status_t               os_reg, os_next;

    logic              out_free;
    logic              ram_we;
    logic [7:0]        ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;
    logic [7:0]        byte_in;
    logic              final_byte;
    logic              completing;
    logic              consume;
    logic [LB-1:0][7:0] word;

    lzbr_ram #(
        .WIDTH (8),
        .DEPTH (lzbr_pkg::WINDOW_DEPTH)
    ) u_history (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !ov_reg || out_ready;

    always_comb begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        dist_next      = dist_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        acc_cnt_next   = acc_cnt_reg;
        acc_next       = acc_reg;
        last_byte_next = last_byte_reg;
        ov_next        = ov_reg && !out_ready;
        od_next        = od_reg;
        oc_next        = oc_reg;
        ol_next        = ol_reg;
        os_next        = os_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = '0;
        ram_raddr      = wp_reg - cmd.distance[AW-1:0];

        // distance one repeats the last byte, which may still be in flight
        byte_in    = (dist_reg == lzbr_pkg::DIST_W'(1)) ? last_byte_reg : ram_rdata;
        final_byte = ((cnt_reg + 1'b1) == len_reg);
        completing = final_byte || (acc_cnt_reg == lzbr_pkg::LANE_IDX_W'(LB - 1));
        consume    = 1'b0;

        for (int k = 0; k < LB; k++) begin
            if (lzbr_pkg::LANE_IDX_W'(k) < acc_cnt_reg) begin
                word[k] = acc_reg[k];
            end else if (lzbr_pkg::LANE_IDX_W'(k) == acc_cnt_reg) begin
                word[k] = byte_in;
            end else begin
                word[k] = 8'd0;
            end
        end

        unique case (state_reg)
            lzbr_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.kind) inside
                        lzbr_pkg::CMD_LITERAL: begin
                            if (out_free) begin
                                cmd_pop        = 1'b1;
                                ram_we         = 1'b1;
                                ram_wdata      = cmd.lit;
                                wp_next        = wp_reg + 1'b1;
                                last_byte_next = cmd.lit;
                                ov_next        = 1'b1;
                                od_next        = lzbr_pkg::DATA_W'(cmd.lit);
                                oc_next        = lzbr_pkg::COUNT_W'(1);
                                ol_next        = 1'b1;
                                os_next        = lzbr_pkg::ST_OK;
                            end
                        end
                        lzbr_pkg::CMD_EMPTY, lzbr_pkg::CMD_FAR: begin
                            if (out_free) begin
                                cmd_pop = 1'b1;
                                ov_next = 1'b1;
                                od_next = '0;
                                oc_next = '0;
                                ol_next = 1'b1;
                                os_next = (cmd.kind == lzbr_pkg::CMD_FAR)
                                        ? lzbr_pkg::ST_FAR : lzbr_pkg::ST_EMPTY;
                            end
                        end
                        lzbr_pkg::CMD_COPY: begin
                            cmd_pop      = 1'b1;
                            state_next   = lzbr_pkg::BK_COPY;
                            dist_next    = cmd.distance;
                            len_next     = cmd.len;
                            cnt_next     = '0;
                            acc_cnt_next = '0;
                        end
                    endcase
                end
            end
            lzbr_pkg::BK_COPY: begin
                consume = !completing || out_free;
                if (consume) begin
                    ram_we         = 1'b1;
                    ram_wdata      = byte_in;
                    wp_next        = wp_reg + 1'b1;
                    last_byte_next = byte_in;
                    cnt_next       = cnt_reg + 1'b1;
                    if (completing) begin
                        ov_next      = 1'b1;
                        od_next      = lzbr_pkg::DATA_W'(word);
                        oc_next      = lzbr_pkg::COUNT_W'(acc_cnt_reg) + lzbr_pkg::COUNT_W'(1);
                        ol_next      = final_byte;
                        os_next      = lzbr_pkg::ST_OK;
                        acc_cnt_next = '0;
                    end else begin
                        acc_next     = word;
                        acc_cnt_next = acc_cnt_reg + 1'b1;
                    end
                end
                // a stalled byte is simply read again from the same address
                ram_raddr = wp_next - dist_reg[AW-1:0];
                if (cnt_next == len_reg) begin
                    state_next = lzbr_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = lzbr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lzbr_pkg::BK_IDLE;
            wp_reg      <= '0;
            cnt_reg     <= '0;
            acc_cnt_reg <= '0;
            ov_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            cnt_reg     <= cnt_next;
            acc_cnt_reg <= acc_cnt_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg      <= dist_next;
        len_reg       <= len_next;
        acc_reg       <= acc_next;
        last_byte_reg <= last_byte_next;
        od_reg        <= od_next;
        oc_reg        <= oc_next;
        ol_reg        <= ol_next;
        os_reg        <= os_next;
    end

    assign out_valid  = ov_reg;
    assign out_data   = od_reg;
    assign out_count  = oc_reg;
    assign out_last   = ol_reg;
    assign out_status = os_reg;

endmodule

`default_nettype wire

// ----- sv/lz77_backref_window_copy_top.sv -----
// Inflate back end with a 32 KiB history window. Each request is a literal
// byte (s_tuser low) or a match of distance and length (s_tuser high); every
// appended byte comes back on the m_ side packed into words of up to eight
// bytes, first byte lowest, with a byte count, tlast on the final word of the
// request and a status in m_tuser (ok, zero distance or zero length, distance
// beyond the history held). The front end classifies requests on arrival and
// queues up to four of them. The back end handles a literal or a status-only
// request directly from idle, while a match enters a copy state and is copied
// one byte at a time, a pace set by the byte-wide history memory with its
// single read port. Output stalls hold the copy in place without losing bytes.
// No clearing pass after reset is needed.
`default_nettype none

module lz77_backref_window_copy_top (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // literal_byte[7:0], distance[23:8], length[32:24], zero[39:33]
    input  wire [lzbr_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode
    input  wire                               s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // data_bytes[63:0], byte_count[67:64], zero[71:68]
    output logic [lzbr_pkg::M_TDATA_W-1:0]    m_tdata,
    // status
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);

    logic                             q_ready;
    logic                             q_push;
    lzbr_pkg::cmd_t                   q_cmd;
    logic                             head_valid;
    lzbr_pkg::cmd_t                   head_cmd;
    logic                             cmd_pop;
    logic [lzbr_pkg::DATA_W-1:0]      out_data;
    logic [lzbr_pkg::COUNT_W-1:0]     out_count;
    lzbr_pkg::status_t                out_status;

    lzbr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .mode         (s_tuser),
        .literal_byte (s_tdata[7:0]),
        .distance     (s_tdata[23:8]),
        .length       (s_tdata[32:24]),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    lzbr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .push_ready (q_ready),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    lzbr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (head_valid),
        .cmd        (head_cmd),
        .cmd_pop    (cmd_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data),
        .out_count  (out_count),
        .out_last   (m_tlast),
        .out_status (out_status)
    );

    assign m_tdata = lzbr_pkg::M_TDATA_W'({out_count, out_data});
    assign m_tuser = out_status;

endmodule

`default_nettype wire

// ----- sv/lzbr_checker.sv -----
`default_nettype none

module lzbr_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [lzbr_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire [1:0]                       m_tuser,
    input wire                             m_tlast
);

    logic [lzbr_pkg::COUNT_W-1:0] count;

    assign count = m_tdata[67:64];

    // a stalled word stays on offer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word dropped or changed while stalled");

    // status words carry no bytes and close their request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != lzbr_pkg::ST_OK |-> count == '0 && m_tlast
            && m_tdata[63:0] == '0)
        else $error("status word with payload or without last");

    // an ok word always carries at least one byte and never more than a lane
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == lzbr_pkg::ST_OK |-> count != '0
            && count <= lzbr_pkg::COUNT_W'(lzbr_pkg::LANE_BYTES))
        else $error("bad byte count on ok word");

    // only the final word of a match may be short
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> count == lzbr_pkg::COUNT_W'(lzbr_pkg::LANE_BYTES))
        else $error("short word before the end of a match");

endmodule

bind lz77_backref_window_copy_top lzbr_checker u_lzbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- dv/lzbr_copy_checker.sv -----
module lzbr_copy_checker (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    input  wire                               s_tready,
    input  wire [lzbr_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire                               s_tuser,
    input  wire                               m_tvalid,
    input  wire                               m_tready,
    input  wire [lzbr_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire [1:0]                         m_tuser,
    input  wire                               m_tlast,
    output int                                errors,
    output int                                pending,
    output int                                requests_seen,
    output int                                words_checked,
    output int                                rejects_seen
);
    import lzbr_pkg::*;

    typedef struct {
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               last;
        status_t            status;
    } out_word_t;

    logic [7:0]        history [0:WINDOW_DEPTH-1];
    logic [ADDR_W-1:0] wptr;
    logic [HELD_W-1:0] held;
    out_word_t         expected_words [$];

    initial begin
        errors        = 0;
        pending       = 0;
        requests_seen = 0;
        words_checked = 0;
        rejects_seen  = 0;
        wptr          = '0;
        held          = '0;
    end

    task automatic append_history(input logic [7:0] b);
        history[wptr] = b;
        wptr = wptr + 1'b1;
        if (held < WINDOW_DEPTH) begin
            held = held + 1'b1;
        end
    endtask

    task automatic push_status_only(input status_t st);
        out_word_t w;
        w.data   = '0;
        w.count  = '0;
        w.last   = 1'b1;
        w.status = st;
        expected_words.push_back(w);
        rejects_seen++;
    endtask

    task automatic predict_request(input logic mode, input logic [7:0] lit,
                                   input logic [DIST_W-1:0] distance,
                                   input logic [LEN_W-1:0] len);
        out_word_t         w;
        int                n_bytes;
        int                done;
        int                k;
        logic [ADDR_W-1:0] src;
        logic [7:0]        b;
        requests_seen++;
        if (mode == MODE_LITERAL) begin
            append_history(lit);
            w.data   = '0;
            w.data[7:0] = lit;
            w.count  = 4'd1;
            w.last   = 1'b1;
            w.status = ST_OK;
            expected_words.push_back(w);
        end else if (distance == '0 || len == '0) begin
            push_status_only(ST_EMPTY);
        end else if (distance > held) begin
            push_status_only(ST_FAR);
        end else begin
            n_bytes = (len > MAX_MATCH) ? MAX_MATCH : int'(len);
            done = 0;
            while (done < n_bytes) begin
                w.data = '0;
                k = 0;
                while (k < LANE_BYTES && done < n_bytes) begin
                    src = wptr - distance[ADDR_W-1:0];
                    b = history[src];
                    append_history(b);
                    w.data[8*k +: 8] = b;
                    k++;
                    done++;
                end
                w.count  = k[COUNT_W-1:0];
                w.last   = (done >= n_bytes);
                w.status = ST_OK;
                expected_words.push_back(w);
            end
        end
    endtask

    task automatic check_word();
        out_word_t w;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word data=%h cnt=%0d last=%b st=%0d", $time,
                     m_tdata[63:0], m_tdata[67:64], m_tlast, m_tuser);
            errors++;
        end else begin
            w = expected_words.pop_front();
            words_checked++;
            if (m_tdata[63:0] !== w.data || m_tdata[67:64] !== w.count ||
                m_tlast !== w.last || m_tuser !== w.status) begin
                $display("%0t: mismatch exp %h/%0d/%b/%0d got %h/%0d/%b/%0d",
                         $time, w.data, w.count, w.last, w.status,
                         m_tdata[63:0], m_tdata[67:64], m_tlast, m_tuser);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            wptr = '0;
            held = '0;
            expected_words.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                predict_request(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[32:24]);
            end
            if (m_tvalid && m_tready) begin
                check_word();
            end
        end
        pending = expected_words.size();
    end

endmodule

// ----- dv/tb_lz77_backref_window_copy_top.sv -----
module tb_lz77_backref_window_copy_top;
    import lzbr_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN       = 400;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    int errors;
    int pending;
    int requests_seen;
    int words_checked;
    int rejects_seen;

    int gap_pct;
    int stall_pct;
    int hold_requests;
    int holds_done;
    int hist;
    int wrapped;

    lz77_backref_window_copy_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lzbr_copy_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .errors        (errors),
        .pending       (pending),
        .requests_seen (requests_seen),
        .words_checked (words_checked),
        .rejects_seen  (rejects_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin
        #(2 * CLK_HALF * 3_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_done != hold_requests) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_done++;
            end else begin
                m_tready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic set_idling(input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    task automatic send_request(input logic mode, input logic [7:0] lit,
                                input logic [DIST_W-1:0] distance,
                                input logic [LEN_W-1:0] len);
        int n;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {7'd0, len, distance, lit};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (mode == MODE_LITERAL) begin
            hist = (hist < WINDOW_DEPTH) ? hist + 1 : hist;
        end else if (distance != 0 && len != 0 && distance <= hist) begin
            n = (len > MAX_MATCH) ? MAX_MATCH : int'(len);
            hist = (hist + n > WINDOW_DEPTH) ? WINDOW_DEPTH : hist + n;
        end
    endtask

    task automatic send_match(input int distance, input int len);
        send_request(MODE_MATCH, 8'($urandom), DIST_W'(distance), LEN_W'(len));
    endtask

    task automatic send_literal(input logic [7:0] b);
        send_request(MODE_LITERAL, b, DIST_W'($urandom), LEN_W'($urandom));
    endtask

    task automatic offer_random_request();
        int r;
        int span;
        int distance;
        int len;
        r = $urandom_range(0, 99);
        if (r < 35 || hist == 0) begin
            send_literal(8'($urandom));
        end else if (r < 85) begin
            span = $urandom_range(0, 9);
            if (span < 6) begin
                distance = $urandom_range(1, (hist < 16) ? hist : 16);
            end else if (span < 9) begin
                distance = $urandom_range(1, (hist < 300) ? hist : 300);
            end else begin
                distance = $urandom_range(1, hist);
            end
            span = $urandom_range(0, 99);
            if (span < 70) begin
                len = $urandom_range(1, 16);
            end else if (span < 90) begin
                len = $urandom_range(17, 64);
            end else if (span < 97) begin
                len = $urandom_range(65, MAX_MATCH);
            end else begin
                len = $urandom_range(MAX_MATCH + 1, 511);
            end
            send_match(distance, len);
        end else begin
            case ($urandom_range(0, 3))
                0: send_match(0, $urandom_range(0, 511));
                1: send_match($urandom_range(0, 65535), 0);
                2: send_match($urandom_range(hist + 1, 65535), $urandom_range(1, 511));
                default: send_match($urandom_range(0, 65535), $urandom_range(0, 511));
            endcase
        end
    endtask

    task automatic run_random(input int n);
        repeat (n) offer_random_request();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = 1'b0;
        s_tdata       = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        hold_requests = 0;
        holds_done    = 0;
        hist          = 0;
        wrapped       = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty history, extremes, overlap, saturation
        set_idling(0, 0);
        send_match(1, 4);
        send_match(0, 0);
        send_request(MODE_LITERAL, 8'h00, '0, '0);
        send_request(MODE_LITERAL, 8'hFF, '1, '1);
        send_literal(8'hA5);
        send_match(1, 1);
        send_match(1, MAX_MATCH);
        send_match(3, 9);
        send_match(2, 8);
        send_match(0, 5);
        send_match(4, 0);
        send_match(hist, 10);
        send_match(hist + 1, 3);
        send_match(WINDOW_DEPTH, 3);
        send_match(65535, MAX_MATCH);
        send_match(5, 511);
        send_match(7, MAX_MATCH + 1);
        send_match(1, 7);
        send_match(16, 17);
        send_literal(8'h5A);
        send_match(1, 3);

        set_idling(0, 0);
        run_random(25);
        set_idling(59, 0);
        run_random(25);
        set_idling(0, 59);
        run_random(25);
        set_idling(35, 35);
        run_random(25);

        // receiver holds off while requests keep coming
        set_idling(0, 0);
        hold_requests++;
        repeat (16) send_match($urandom_range(1, 8), $urandom_range(40, MAX_MATCH));

        // fill the whole window so the ring wraps
        set_idling(0, 0);
        while (hist < WINDOW_DEPTH) begin
            if ($urandom_range(0, 9) == 0) begin
                send_literal(8'($urandom));
            end else begin
                send_match($urandom_range(1, (hist < 4096) ? hist : 4096), MAX_MATCH);
            end
        end
        wrapped = 1;

        set_idling(35, 35);
        send_match(WINDOW_DEPTH, 20);
        send_match(WINDOW_DEPTH + 1, 5);
        repeat (30) begin
            case ($urandom_range(0, 3))
                0: send_match(WINDOW_DEPTH, $urandom_range(1, 40));
                1: send_literal(8'($urandom));
                default: send_match($urandom_range(1, WINDOW_DEPTH), $urandom_range(1, 40));
            endcase
        end
        run_random(20);

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);

        $display("checked %0d requests and %0d output words, %0d of them status-only",
                 requests_seen, words_checked, rejects_seen);
        $display("idling phases, long output hold-off, window fill and wrap (%0d)", wrapped);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
